FILE: rtl/prs_pkg.sv
`timescale 1ns / 1ps
package prs_pkg;

	localparam int MAX_SAMPLES  = 1048576;
	localparam int SRC_W        = $clog2(MAX_SAMPLES);
	localparam int PER_ITEM_MAX = 16;
	localparam int N_W          = $clog2(PER_ITEM_MAX + 1);

	localparam int STEP_W  = 12;
	localparam int WIDTH_W = 2;
	localparam int LIMIT_W = 21;
	localparam int PHASE_W = 32;
	localparam int SAMP_W  = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd3;

	localparam logic [WIDTH_W-1:0] WIDTH_16 = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [STEP_W-1:0]  phase_step;
		logic [WIDTH_W-1:0] in_width;
		logic [WIDTH_W-1:0] out_width;
		logic [LIMIT_W-1:0] output_limit;
	} cfg_t;

	typedef struct packed {
		logic [SAMP_W-1:0] sample;
		logic              restart;
	} entry_t;

endpackage

FILE: rtl/prs_front.sv
`timescale 1ns / 1ps
module prs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  prs_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [15:0]             sample_in,
	input  logic                    restart,
	output logic                    q_valid,
	output prs_pkg::entry_t         q_entry,
	input  logic                    q_pop
);
	import prs_pkg::*;

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [SAMP_W-1:0]   v16;
	logic [SAMP_W-1:0]   conv;
	logic                push;
	logic                pop;

	// 8-bit input: flip bias bit, move to top byte; 8-bit output: top byte, sign-extended
	always_comb begin
		if (cfg.in_width == WIDTH_16) begin
			v16 = sample_in;
		end else begin
			v16 = {~sample_in[7], sample_in[6:0], 8'h00};
		end
		if (cfg.out_width == WIDTH_16) begin
			conv = v16;
		end else begin
			conv = {{8{v16[15]}}, v16[15:8]};
		end
	end

	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_pop;
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{sample: conv, restart: restart};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/prs_back.sv
`timescale 1ns / 1ps
module prs_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  prs_pkg::cfg_t           cfg,
	input  logic                    q_valid,
	input  prs_pkg::entry_t         q_entry,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [15:0]      out_sample,
	output logic                    last
);
	import prs_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                st_q;
	logic [SAMP_W-1:0]   conv_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [SRC_W-1:0]    idx_q;
	logic [LIMIT_W-1:0]  cnt_q;
	logic [N_W-1:0]      n_q;
	logic                out_valid_q;
	logic [SAMP_W-1:0]   out_sample_q;
	logic                last_q;
	logic                slot_free;
	logic                emit_ok;
	logic                emit;
	logic [LIMIT_W-1:0]  cnt_nxt;

	assign slot_free = !out_valid_q || !out_stall;
	assign cnt_nxt   = cnt_q + 1'b1;
	assign emit_ok   = (n_q != N_W'(PER_ITEM_MAX)) && (cnt_q < cfg.output_limit) &&
	                   (phase_q[31:8] <= 24'(idx_q));
	assign emit      = (st_q == ST_RUN) && emit_ok && slot_free;
	assign q_pop     = (st_q == ST_IDLE);

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign last       = last_q;

	always_ff @(posedge clk) begin
		if (q_pop && q_valid) begin
			conv_q <= q_entry.sample;
		end
		if (emit) begin
			out_sample_q <= conv_q;
			last_q       <= (cnt_nxt == cfg.output_limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= emit;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_entry.restart) begin
							phase_q <= '0;
							idx_q   <= '0;
							cnt_q   <= '0;
						end
						n_q  <= '0;
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!emit_ok) begin
						// index holds at the last position once the end is reached
						if (idx_q != SRC_W'(MAX_SAMPLES - 1)) begin
							idx_q <= idx_q + 1'b1;
						end
						st_q <= ST_IDLE;
					end else if (slot_free) begin
						cnt_q   <= cnt_nxt;
						phase_q <= phase_q + PHASE_W'(cfg.phase_step);
						n_q     <= n_q + 1'b1;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/pcm_phase_step_resampler.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    sample_in[15:0], restart
// out      source     out_valid / out_stall  out_sample[15:0] signed, last
// cfg      sink       cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[20:0]
//
// An item yields 0..16 outputs, set by the single emission loop in the back end;
// outputs leave one per cycle while out_stall is low.
// A two-entry queue sits between input conversion and the emission loop.
// Reset clears control/config registers at once, no clearing pass; queue and output data stay.
// out_stall holds the output register and pauses emission; in_stall rises when the queue is full.
module pcm_phase_step_resampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [15:0]                       sample_in,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                out_sample,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import prs_pkg::*;

	cfg_t   cfg_q;
	logic   q_valid;
	entry_t q_entry;
	logic   q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step   <= STEP_W'(256);
			cfg_q.in_width     <= WIDTH_16;
			cfg_q.out_width    <= WIDTH_16;
			cfg_q.output_limit <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data[STEP_W-1:0];
				REG_IN_WIDTH:     cfg_q.in_width     <= cfg_data[WIDTH_W-1:0];
				REG_OUT_WIDTH:    cfg_q.out_width    <= cfg_data[WIDTH_W-1:0];
				REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	prs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.restart   (restart),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	prs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.last       (last)
	);

endmodule

FILE: sim/pcm_phase_step_resampler_tb.sv
`timescale 1ns / 1ps
module pcm_phase_step_resampler_tb;
	import prs_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	// three queued items of sixteen outputs each, plus margin
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SEGMENT_ITEMS = 50;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 3'd7;
	localparam logic [LIMIT_W-1:0]   LIMIT_MAX        = '1;
	localparam logic [WIDTH_W-1:0]   WIDTH_8          = 2'd1;
	// other codes that also select the 8-bit format
	localparam logic [WIDTH_W-1:0]   WIDTH_8_ZERO     = 2'd0;
	localparam logic [WIDTH_W-1:0]   WIDTH_8_THREE    = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [15:0]            sample_in;
	logic                   restart;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [15:0]     out_sample;
	logic                   last;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	typedef struct {
		logic signed [SAMP_W-1:0] pcm;
		logic                     last_flag;
	} resampled_t;

	resampled_t due_outputs[$];

	// predictor copy of registers and state
	logic [STEP_W-1:0]  m_step;
	logic [WIDTH_W-1:0] m_in_w;
	logic [WIDTH_W-1:0] m_out_w;
	logic [LIMIT_W-1:0] m_limit;
	logic [31:0]        m_phase;
	logic [23:0]        m_src;
	logic [LIMIT_W-1:0] m_count;

	int errors;
	int cycles;
	int items_sent;
	int results_seen;
	int reg_writes;
	int tx_idle_pct;
	int rx_idle_pct;

	pcm_phase_step_resampler uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_outputs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin : check_results
		resampled_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_outputs.size() == 0) begin
				$error("unexpected result: out_sample %0d last %0b", out_sample, last);
				errors++;
			end else begin
				want = due_outputs.pop_front();
				if (out_sample !== want.pcm) begin
					$error("out_sample: expected %0d, got %0d", want.pcm, out_sample);
					errors++;
				end
				if (last !== want.last_flag) begin
					$error("last: expected %0b, got %0b", want.last_flag, last);
					errors++;
				end
				results_seen++;
			end
		end
	end

	function automatic logic [SAMP_W-1:0] convert_pcm(input logic [SAMP_W-1:0] raw);
		logic [SAMP_W-1:0] wide;
		if (m_in_w == WIDTH_16)
			wide = raw;
		else
			wide = {raw[7:0] ^ 8'h80, 8'h00};
		if (m_out_w == WIDTH_16)
			return wide;
		return {{8{wide[15]}}, wide[15:8]};
	endfunction

	// outputs due while the integer phase has not passed the current source index, up to sixteen per item and the limit
	task automatic resample_item(input logic [SAMP_W-1:0] raw, input logic rst);
		logic [SAMP_W-1:0] conv;
		resampled_t r;
		int n;
		if (rst) begin
			m_phase = '0;
			m_src   = '0;
			m_count = '0;
		end
		conv = convert_pcm(raw);
		n = 0;
		while (n < PER_ITEM_MAX && m_count < m_limit && (m_phase >> 8) <= {8'd0, m_src}) begin
			m_count = m_count + 1'b1;
			m_phase = m_phase + {20'd0, m_step};
			r.pcm = conv;
			r.last_flag = (m_count == m_limit);
			due_outputs.push_back(r);
			n++;
		end
		if (m_src < 24'(MAX_SAMPLES - 1))
			m_src = m_src + 1'b1;
	endtask

	task automatic send_item(input logic [SAMP_W-1:0] raw, input logic rst);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= raw;
		restart   <= rst;
		do @(posedge clk); while (in_stall);
		resample_item(raw, rst);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PHASE_STEP:   m_step  = data[STEP_W-1:0];
			REG_IN_WIDTH:     m_in_w  = data[WIDTH_W-1:0];
			REG_OUT_WIDTH:    m_out_w = data[WIDTH_W-1:0];
			REG_OUTPUT_LIMIT: m_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// junk in the unused upper bits checks the register masking
	task automatic configure(input logic [STEP_W-1:0] step, input logic [WIDTH_W-1:0] inw,
			input logic [WIDTH_W-1:0] outw, input logic [LIMIT_W-1:0] lim);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_PHASE_STEP, {junk[CFG_DATA_W-1:STEP_W], step});
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_IN_WIDTH, {junk[CFG_DATA_W-1:WIDTH_W], inw});
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_OUT_WIDTH, {junk[CFG_DATA_W-1:WIDTH_W], outw});
		write_reg(REG_OUTPUT_LIMIT, lim);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold the sender until every due output is out and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// limit resets to zero, so nothing should come out
	task automatic test_reset_state();
		send_item(16'h1234, 1'b0);
		send_item(16'hFFFF, 1'b1);
		settle();
	endtask

	task automatic test_register_masking();
		for (int i = int'(REG_FIRST_UNUSED); i <= int'(REG_LAST_UNUSED); i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
		configure(12'd256, WIDTH_16, WIDTH_16, 21'd6);
		send_item(16'h0000, 1'b1);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h5A5A, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'h1234, 1'b0);
		settle();
	endtask

	task automatic test_width_modes();
		configure(12'd256, WIDTH_8, WIDTH_8, LIMIT_MAX);
		send_item(16'h1200, 1'b1);
		send_item(16'hAB80, 1'b0);
		send_item(16'h00FF, 1'b0);
		send_item(16'hFF7F, 1'b0);
		settle();
		configure(12'd256, WIDTH_8_ZERO, WIDTH_16, LIMIT_MAX);
		send_item(16'h3400, 1'b1);
		send_item(16'h00FF, 1'b0);
		settle();
		configure(12'd256, WIDTH_16, WIDTH_8_THREE, LIMIT_MAX);
		send_item(16'h8000, 1'b1);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h0080, 1'b0);
		settle();
	endtask

	// more than sixteen due per item: the backlog spills over to later items
	task automatic test_small_step();
		configure(12'd5, WIDTH_16, WIDTH_16, 21'd40);
		send_item(16'h1111, 1'b1);
		send_item(16'h2222, 1'b0);
		send_item(16'h3333, 1'b0);
		settle();
	endtask

	// phase frozen: sixteen per item up to the limit, then silence until restart
	task automatic test_zero_step();
		configure(12'd0, WIDTH_16, WIDTH_8, 21'd20);
		send_item(16'hC3A5, 1'b1);
		send_item(16'h4B2D, 1'b0);
		send_item(16'h9999, 1'b0);
		send_item(16'h7E01, 1'b1);
		settle();
	endtask

	task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
		logic [STEP_W-1:0]  step;
		logic [LIMIT_W-1:0] lim;
		int sent;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			settle();
			case ($urandom_range(7))
				0:       step = STEP_W'($urandom_range(0, 15));
				1:       step = 12'd16;
				2:       step = '1;
				3:       step = STEP_W'($urandom_range(240, 272));
				default: step = STEP_W'($urandom_range(16, 1024));
			endcase
			case ($urandom_range(5))
				0:       lim = LIMIT_W'($urandom_range(0, 3));
				1:       lim = LIMIT_MAX;
				default: lim = LIMIT_W'($urandom_range(64, 1500));
			endcase
			configure(step, WIDTH_W'($urandom_range(0, 3)), WIDTH_W'($urandom_range(0, 3)), lim);
			for (int k = 0; k < SEGMENT_ITEMS && sent < n_items; k++) begin
				send_item(SAMP_W'($urandom),
					(k == 0 && $urandom_range(1) == 1) || $urandom_range(99) < 4);
				sent++;
			end
		end
		settle();
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_in    = '0;
		restart      = 1'b0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		errors       = 0;
		cycles       = 0;
		items_sent   = 0;
		results_seen = 0;
		reg_writes   = 0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		m_step  = 12'd256;
		m_in_w  = WIDTH_16;
		m_out_w = WIDTH_16;
		m_limit = '0;
		m_phase = '0;
		m_src   = '0;
		m_count = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 38;
		rx_idle_pct = 56;
		test_reset_state();
		test_register_masking();
		test_width_modes();
		test_small_step();
		test_zero_step();
		test_random_traffic(150, 38, 56);
		test_random_traffic(150, 56, 38);
		test_random_traffic(150, 0, 0);
		settle();

		$display("%0d items in, %0d outputs checked, %0d register writes", items_sent,
			results_seen, reg_writes);
		$display("covered: both sample formats, zero/small/max step, limits and restarts");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
